// ===== hw/rtl/nte_pkg.sv =====
// Package for the NAL to Annex B escape block: entry types, opcodes, constants.
// Used by the front, queue, back and top level; depends on nothing.
`timescale 1ns / 1ps

package nte_pkg;

	localparam int unsigned HEAD_LEN   = 4;
	localparam int unsigned FIFO_DEPTH = 4;

	localparam logic [4:0] TYPE_MASK = 5'h1f;
	localparam logic [4:0] TYPE_IDR  = 5'd5;
	localparam logic [4:0] TYPE_SPS  = 5'd7;
	localparam logic [4:0] TYPE_PPS  = 5'd8;
	localparam logic [7:0] ESC_BYTE  = 8'h03;
	localparam logic [7:0] SC_ONE    = 8'h01;

	// What the back part does with one queued transaction
	typedef enum logic [1:0] {
		OP_PASS      = 2'd0,  // one body byte, copied unchanged
		OP_ESC       = 2'd1,  // one body byte, with emulation prevention
		OP_HEAD_PASS = 2'd2,  // the held start code of a NAL that already had one
		OP_HEAD_ESC  = 2'd3   // new start code, header byte, escaped held bytes
	} nte_op_t;

	typedef struct packed {
		nte_op_t          op;
		logic [3:0][7:0]  hold;     // held head bytes; body ops use hold[0]
		logic [2:0]       count;    // held bytes, 1 to 4, for OP_HEAD_ESC
		logic             nal_end;
		logic             key;
	} nte_entry_t;

	// Byte of the 00 00 00 01 start code at position idx
	function automatic logic [7:0] start_code_byte(input logic [1:0] idx);
		logic [7:0] b;
		b = (idx == 2'd3) ? SC_ONE : 8'h00;
		return b;
	endfunction

endpackage

// ===== hw/rtl/nte_if.sv =====
// Valid/ready channel interfaces for the NAL input and the Annex B output.
// No dependencies.
`timescale 1ns / 1ps

interface nte_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       nal_end;

	modport source (output valid, output data_byte, output nal_end, input ready);
	modport sink   (input valid, input data_byte, input nal_end, output ready);
endinterface

interface nte_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic       key_nal;
	logic       run_last;

	modport source (output valid, output out_byte, output out_last, output key_nal,
		output run_last, input ready);
	modport sink   (input valid, input out_byte, input out_last, input key_nal,
		input run_last, output ready);
endinterface

// ===== hw/rtl/nte_front.sv =====
// Front part: accepts NAL bytes, collects the head, classifies each byte into a queue entry.
// Depends on nte_pkg and nte_if.
`timescale 1ns / 1ps

module nte_front import nte_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	nte_in_if.sink       nal,
	output logic         push_valid,
	output nte_entry_t   push_entry,
	input  logic         push_ready
);

	logic [2:0]      head_count_q;
	logic            pass_q;
	logic            key_q;
	logic [3:0][7:0] hold_q;

	logic            accept;
	logic            in_head;
	logic            head_full;
	logic            is_start;
	logic            key_new;
	logic            key_cur;
	logic [4:0]      hdr_type;
	logic [3:0][7:0] hold_next;

	assign nal.ready = push_ready;
	assign accept    = nal.valid && push_ready;

	// Classify the incoming byte
	always_comb begin
		in_head   = head_count_q < 3'(HEAD_LEN);
		head_full = in_head && (head_count_q == 3'(HEAD_LEN - 1));
		hdr_type  = nal.data_byte[4:0] & TYPE_MASK;
		key_new   = (hdr_type == TYPE_IDR) || (hdr_type == TYPE_SPS) ||
			(hdr_type == TYPE_PPS);
		key_cur   = (head_count_q == 3'd0) ? key_new : key_q;
		hold_next = hold_q;
		if (in_head) begin
			hold_next[head_count_q[1:0]] = nal.data_byte;
		end
		is_start  = (hold_next[0] == 8'h00) && (hold_next[1] == 8'h00) &&
			(hold_next[2] == 8'h00) && (hold_next[3] == SC_ONE);
	end

	// Build the queue entry
	always_comb begin
		push_entry.hold    = hold_next;
		push_entry.nal_end = nal.nal_end;
		push_entry.key     = key_cur;
		push_entry.count   = 3'd1;
		push_entry.op      = OP_ESC;
		push_valid         = 1'b0;
		if (in_head) begin
			if (head_full) begin
				push_entry.op    = is_start ? OP_HEAD_PASS : OP_HEAD_ESC;
				push_entry.count = 3'(HEAD_LEN);
				push_valid       = accept;
			end else if (nal.nal_end) begin
				push_entry.op    = OP_HEAD_ESC;
				push_entry.count = head_count_q + 3'd1;
				push_valid       = accept;
			end
		end else begin
			push_entry.hold[0] = nal.data_byte;
			push_entry.op      = pass_q ? OP_PASS : OP_ESC;
			push_valid         = accept;
		end
	end

	// Advance the head state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_count_q <= 3'd0;
			pass_q       <= 1'b0;
			key_q        <= 1'b0;
		end else if (accept) begin
			if (nal.nal_end) begin
				head_count_q <= 3'd0;
				pass_q       <= 1'b0;
				key_q        <= 1'b0;
			end else begin
				key_q <= key_cur;
				if (in_head) begin
					head_count_q <= head_count_q + 3'd1;
				end
				if (head_full) begin
					pass_q <= is_start;
				end
			end
		end
	end

	// Hold the head bytes
	always_ff @(posedge clk) begin
		if (accept && in_head) begin
			hold_q <= hold_next;
		end
	end

endmodule

// ===== hw/rtl/nte_fifo.sv =====
// Short queue of classified entries between the front and back parts.
// Depends on nte_pkg.
`timescale 1ns / 1ps

module nte_fifo import nte_pkg::*; #(
	parameter int unsigned Depth = FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	input  nte_entry_t push_entry,
	output logic       push_ready,
	output logic       pop_valid,
	output nte_entry_t pop_entry,
	input  logic       pop
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	nte_entry_t      mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = count_q != CntW'(Depth);
	assign pop_valid  = count_q != '0;
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ===== hw/rtl/nte_back.sv =====
// Back part: expands each queued entry into output bytes, inserts escape bytes.
// Depends on nte_pkg and nte_if.
`timescale 1ns / 1ps

module nte_back import nte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  nte_entry_t q_entry,
	output logic       q_pop,
	nte_out_if.source  annexb
);

	logic [2:0] pos_q;
	logic       esc_q;
	logic [1:0] zero_run_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       key_q;
	logic       run_last_q;

	logic [7:0] cur_byte;
	logic       escapable;
	logic       is_final;
	logic       clear_run;
	logic       need_esc;
	logic       advance;

	assign annexb.valid    = out_valid_q;
	assign annexb.out_byte = out_byte_q;
	assign annexb.out_last = out_last_q;
	assign annexb.key_nal  = key_q;
	assign annexb.run_last = run_last_q;

	// Select the byte at the current position of the entry
	always_comb begin
		cur_byte  = q_entry.hold[0];
		escapable = 1'b0;
		is_final  = 1'b1;
		clear_run = 1'b0;
		case (q_entry.op)
			OP_PASS: begin
				escapable = 1'b0;
			end
			OP_ESC: begin
				escapable = 1'b1;
			end
			OP_HEAD_PASS: begin
				cur_byte = start_code_byte(pos_q[1:0]);
				is_final = pos_q == 3'(HEAD_LEN - 1);
			end
			OP_HEAD_ESC: begin
				cur_byte  = pos_q[2] ? q_entry.hold[pos_q[1:0]] : start_code_byte(pos_q[1:0]);
				escapable = pos_q[2] && (pos_q[1:0] != 2'd0);
				clear_run = pos_q == 3'(HEAD_LEN);
				is_final  = pos_q == (q_entry.count + 3'(HEAD_LEN - 1));
			end
			default: begin
				escapable = 1'b0;
			end
		endcase
		need_esc = escapable && (zero_run_q == 2'd2) && (cur_byte <= ESC_BYTE) && !esc_q;
		advance  = q_valid && (!out_valid_q || annexb.ready);
		q_pop    = advance && !need_esc && is_final;
	end

	// Step through the entry and track the zero run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 3'd0;
			esc_q       <= 1'b0;
			zero_run_q  <= 2'd0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
			if (need_esc) begin
				esc_q      <= 1'b1;
				zero_run_q <= 2'd0;
			end else begin
				esc_q <= 1'b0;
				pos_q <= is_final ? 3'd0 : pos_q + 3'd1;
				if ((is_final && q_entry.nal_end) || clear_run) begin
					zero_run_q <= 2'd0;
				end else if (escapable) begin
					if (cur_byte == 8'h00) begin
						zero_run_q <= (zero_run_q == 2'd2) ? 2'd2 : zero_run_q + 2'd1;
					end else begin
						zero_run_q <= 2'd0;
					end
				end
			end
		end else if (annexb.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (advance) begin
			key_q <= q_entry.key;
			if (need_esc) begin
				out_byte_q <= ESC_BYTE;
				out_last_q <= 1'b0;
				run_last_q <= 1'b0;
			end else begin
				out_byte_q <= cur_byte;
				out_last_q <= is_final && q_entry.nal_end;
				run_last_q <= is_final;
			end
		end
	end

endmodule

// ===== hw/rtl/nal_to_annexb_escape.sv =====
// NAL to Annex B converter: start code insertion and emulation prevention.
// Body bytes pass the entry queue and the output register; head bytes wait for the fourth.
// Throughput: one input byte per cycle while the entry queue has room; the back part sends
// a head as start code and held bytes, and an escape byte before each escaped byte.
// Reset (arst_n, asynchronous) clears head state, queue and output register; no sweep.
`timescale 1ns / 1ps

module nal_to_annexb_escape import nte_pkg::*; #(
	parameter int unsigned FifoDepth = FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	nte_in_if.sink     nal,
	nte_out_if.source  annexb
);

	logic       push_valid;
	nte_entry_t push_entry;
	logic       push_ready;
	logic       q_valid;
	nte_entry_t q_entry;
	logic       q_pop;

	// Classify input bytes
	nte_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.nal        (nal),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready)
	);

	// Queue entries
	nte_fifo #(
		.Depth (FifoDepth)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop_valid  (q_valid),
		.pop_entry  (q_entry),
		.pop        (q_pop)
	);

	// Expand entries into output bytes
	nte_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_pop   (q_pop),
		.annexb  (annexb)
	);

	// The final byte of a NAL always closes the run of its input byte
	a_last_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		annexb.valid && annexb.out_last |-> annexb.run_last)
		else $error("out_last without run_last");

	// Within a run the next result follows without a gap
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		annexb.valid && annexb.ready && !annexb.run_last |=> annexb.valid)
		else $error("gap inside a result run");

	// Input stalls only while the queue holds entries
	a_stall_queue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!nal.ready |-> q_valid)
		else $error("input stalled with empty queue");

endmodule
